### hdl/dekin_pkg.sv
// Shared constants, widths and result helpers for the electron kinematics pipeline.
package dekin_pkg;

	localparam int MOM_W     = 24;
	localparam int RES_W     = 32;
	localparam int BEAM_W    = 20;
	localparam int CFG_IDX_W = 8;
	localparam int QB        = 31;
	localparam int FRAC      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BEAM  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EARLY = 8'd1;

	localparam logic [BEAM_W-1:0] BEAM_RST  = 20'd694682;
	localparam logic              EARLY_RST = 1'b1;

	localparam logic [47:0]        ME2_Q32  = 48'd1121;
	localparam logic signed [25:0] MP_Q16   = 26'sd61491;
	localparam logic signed [17:0] TWO_MP   = 18'sd122982;
	localparam logic signed [31:0] W_CUT    = 32'sd131072;
	localparam logic signed [31:0] SENTINEL = -32'sd655360000;
	localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'(S32_MAX)) r = S32_MAX;
		else if (v < 35'(S32_MIN)) r = S32_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] ratio_fix(input logic [QB-1:0] q, input logic ovf,
			input logic neg, input logic numneg, input logic nzero, input logic dzero);
		logic signed [31:0] r;
		priority if (dzero) begin
			r = !nzero ? '0 : (numneg ? S32_MIN : S32_MAX);
		end else if (ovf) begin
			r = neg ? S32_MIN : S32_MAX;
		end else if (neg) begin
			r = -$signed({1'b0, q});
		end else begin
			r = $signed({1'b0, q});
		end
		return r;
	endfunction

endpackage

### hdl/dekin_if.sv
// Channel interfaces: electron momentum in, kinematics result out.
interface dekin_mom_if import dekin_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MOM_W-1:0]  mom_x;
	logic signed [MOM_W-1:0]  mom_y;
	logic signed [MOM_W-1:0]  mom_z;
	modport source(output valid, mom_x, mom_y, mom_z, input ready);
	modport sink(input valid, mom_x, mom_y, mom_z, output ready);
endinterface

interface dekin_kin_if import dekin_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RES_W-1:0]  inv_mass_w;
	logic signed [RES_W-1:0]  q_squared;
	logic signed [RES_W-1:0]  energy_transfer;
	logic signed [RES_W-1:0]  bjorken_x;
	logic signed [RES_W-1:0]  boost_x;
	logic signed [RES_W-1:0]  boost_y;
	logic signed [RES_W-1:0]  boost_z;
	logic                     full_result;
	logic                     divide_fault;
	modport source(output valid, inv_mass_w, q_squared, energy_transfer, bjorken_x,
		boost_x, boost_y, boost_z, full_result, divide_fault, input ready);
	modport sink(input valid, inv_mass_w, q_squared, energy_transfer, bjorken_x,
		boost_x, boost_y, boost_z, full_result, divide_fault, output ready);
endinterface

### hdl/dekin_sqrt_pipe.sv
// Pipelined floor square root, one result bit per stage.
module dekin_sqrt_pipe #(
	parameter int N  = 24,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  logic [2*N-1:0]  rad,
	input  logic [SW-1:0]   sb_in,
	output logic            vout,
	output logic [N-1:0]    root,
	output logic [SW-1:0]   sb_out
);

	logic           v_q    [0:N];
	logic [N:0]     rem_q  [0:N];
	logic [N-1:0]   root_q [0:N];
	logic [2*N-1:0] rad_q  [0:N];
	logic [SW-1:0]  sb_q   [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else if (en) v_q[0] <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			rad_q[0]  <= rad;
			sb_q[0]   <= sb_in;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+1:0] cand;
		logic [N+1:0] trial;
		logic [N+1:0] diff;
		logic         ge;

		assign cand  = {rem_q[k][N-1:0], rad_q[k][2*N-1 -: 2]};
		assign trial = {root_q[k], 2'b01};
		assign ge    = cand >= trial;
		assign diff  = ge ? cand - trial : cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else if (en) v_q[k+1] <= v_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= diff[N:0];
				root_q[k+1] <= {root_q[k][N-2:0], ge};
				rad_q[k+1]  <= rad_q[k] << 2;
				sb_q[k+1]   <= sb_q[k];
			end
		end
	end

	assign vout   = v_q[N];
	assign root   = root_q[N];
	assign sb_out = sb_q[N];

endmodule

### hdl/dekin_div_pipe.sv
// Pipelined restoring divider giving floor(num * 2^16 / den), one quotient bit per stage.
module dekin_div_pipe import dekin_pkg::*; #(
	parameter int NW    = 51,
	parameter int DW    = 44,
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  logic [LANES-1:0][NW-1:0]      num,
	input  logic [DW-1:0]                 den,
	input  logic [SW-1:0]                 sb_in,
	output logic                          vout,
	output logic [LANES-1:0][QB-1:0]      quo,
	output logic [LANES-1:0]              ovf,
	output logic [SW-1:0]                 sb_out
);

	localparam int W = (NW + FRAC > DW + QB) ? NW + FRAC : DW + QB;

	logic                     v_q   [0:QB];
	logic [LANES-1:0][W-1:0]  rem_q [0:QB];
	logic [LANES-1:0][QB-1:0] quo_q [0:QB];
	logic [LANES-1:0]         ovf_q [0:QB];
	logic [DW-1:0]            den_q [0:QB];
	logic [SW-1:0]            sb_q  [0:QB];

	logic [LANES-1:0][W-1:0]  rem_in;
	logic [LANES-1:0]         ovf_in;
	logic [W-1:0]             den_top;

	assign den_top = W'(den) << QB;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_in[l] = W'(num[l]) << FRAC;
			ovf_in[l] = rem_in[l] >= den_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else if (en) v_q[0] <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_in;
			quo_q[0] <= '0;
			ovf_q[0] <= ovf_in;
			den_q[0] <= den;
			sb_q[0]  <= sb_in;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int SH = QB - 1 - k;
		logic [W-1:0]             dsh;
		logic [LANES-1:0][W-1:0]  rem_nx;
		logic [LANES-1:0][QB-1:0] quo_nx;

		assign dsh = W'(den_q[k]) << SH;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (rem_q[k][l] >= dsh) begin
					rem_nx[l] = rem_q[k][l] - dsh;
					quo_nx[l] = quo_q[k][l] | (QB'(1) << SH);
				end else begin
					rem_nx[l] = rem_q[k][l];
					quo_nx[l] = quo_q[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else if (en) v_q[k+1] <= v_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= rem_nx;
				quo_q[k+1] <= quo_nx;
				ovf_q[k+1] <= ovf_q[k];
				den_q[k+1] <= den_q[k];
				sb_q[k+1]  <= sb_q[k];
			end
		end
	end

	assign vout   = v_q[QB];
	assign quo    = quo_q[QB];
	assign ovf    = ovf_q[QB];
	assign sb_out = sb_q[QB];

endmodule

### hdl/dis_electron_kinematics_unit.sv
// Throughput: one beat per cycle; the whole pipeline advances together and holds
// only while the output register is full and not taken.
// Depth is set by the two square root chains (24 and 25 bits) and two 31-bit dividers.
// Reset clears all valid bits; beam energy returns to 10.6 GeV and early-out is on.
module dis_electron_kinematics_unit import dekin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [BEAM_W-1:0]    wr_data,
	dekin_mom_if.sink            mom,
	dekin_kin_if.source          kin
);

	typedef struct packed {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [24:0] pmz;
		logic [19:0]        eb;
		logic               eo;
		logic [47:0]        sxy;
		logic [46:0]        wz2;
	} sb1_t;

	typedef struct packed {
		logic               mneg;
		logic signed [50:0] q2;
		logic signed [43:0] denx;
		logic signed [25:0] qe;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [24:0] pmz;
		logic               eo;
	} sb2_t;

	typedef struct packed {
		logic signed [31:0] w32;
		logic               early;
		logic signed [31:0] q2o;
		logic signed [25:0] qe;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [24:0] pmz;
		logic               xneg;
		logic               xnumneg;
		logic               xnz;
		logic               xdz;
	} sb3_t;

	typedef struct packed {
		logic signed [31:0] w32;
		logic               early;
		logic signed [31:0] q2o;
		logic signed [25:0] qe;
		logic signed [31:0] xo;
		logic               xdz;
		logic               bdz;
		logic               bdneg;
		logic [2:0]         nneg;
		logic [2:0]         nnz;
	} sb4_t;

	logic [BEAM_W-1:0] beam_q;
	logic              early_q;
	logic              adv;

	assign adv       = !kin.valid || kin.ready;
	assign mom.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q  <= BEAM_RST;
			early_q <= EARLY_RST;
		end else if (wr_en) begin
			if (wr_index == REG_BEAM) beam_q <= wr_data;
			if (wr_index == REG_EARLY) early_q <= wr_data[0];
		end
	end

	// stage 1: capture beat and configuration
	logic               v_s1, eo_s1;
	logic signed [23:0] px_s1, py_s1, pz_s1;
	logic [19:0]        eb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= mom.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= mom.mom_x;
			py_s1 <= mom.mom_y;
			pz_s1 <= mom.mom_z;
			eb_s1 <= beam_q;
			eo_s1 <= early_q;
		end
	end

	// stage 2: squares of momentum
	logic signed [47:0] sqx_c, sqy_c, sqz_c;
	logic signed [24:0] wz_c, pmz_c;
	logic               v_s2, eo_s2;
	logic [46:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [24:0] wz_s2, pmz_s2;
	logic signed [23:0] px_s2, py_s2;
	logic [19:0]        eb_s2;

	assign sqx_c = px_s1 * px_s1;
	assign sqy_c = py_s1 * py_s1;
	assign sqz_c = pz_s1 * pz_s1;
	assign wz_c  = $signed({5'b0, eb_s1}) - 25'(pz_s1);
	assign pmz_c = 25'(pz_s1) - $signed({5'b0, eb_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= sqx_c[46:0];
			sqy_s2 <= sqy_c[46:0];
			sqz_s2 <= sqz_c[46:0];
			wz_s2  <= wz_c;
			pmz_s2 <= pmz_c;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			eb_s2  <= eb_s1;
			eo_s2  <= eo_s1;
		end
	end

	// electron energy
	logic signed [49:0] wz2_c;
	logic [47:0]        rad1;
	sb1_t               sb1_in, sb1_out;
	logic               v_e;
	logic [23:0]        ee;

	assign wz2_c = wz_s2 * wz_s2;
	assign rad1  = 48'(sqx_s2) + 48'(sqy_s2) + 48'(sqz_s2) + ME2_Q32;

	always_comb begin
		sb1_in     = '0;
		sb1_in.px  = px_s2;
		sb1_in.py  = py_s2;
		sb1_in.pmz = pmz_s2;
		sb1_in.eb  = eb_s2;
		sb1_in.eo  = eo_s2;
		sb1_in.sxy = 48'(sqx_s2) + 48'(sqy_s2);
		sb1_in.wz2 = wz2_c[46:0];
	end

	dekin_sqrt_pipe #(.N(24), .SW($bits(sb1_t))) u_sqrt_e (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (v_s2),
		.rad    (rad1),
		.sb_in  (sb1_in),
		.vout   (v_e),
		.root   (ee),
		.sb_out (sb1_out)
	);

	// stage 4: energy transfer and W energy
	logic               v_s4, eo_s4;
	logic signed [25:0] qe_s4, we_s4;
	logic signed [23:0] px_s4, py_s4;
	logic signed [24:0] pmz_s4;
	logic [47:0]        sxy_s4;
	logic [46:0]        wz2_s4;
	logic signed [25:0] qe_c;

	assign qe_c = $signed({6'b0, sb1_out.eb}) - $signed({2'b0, ee});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_e;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qe_s4  <= qe_c;
			we_s4  <= qe_c + MP_Q16;
			px_s4  <= sb1_out.px;
			py_s4  <= sb1_out.py;
			pmz_s4 <= sb1_out.pmz;
			eo_s4  <= sb1_out.eo;
			sxy_s4 <= sb1_out.sxy;
			wz2_s4 <= sb1_out.wz2;
		end
	end

	// stage 5: energy squares and x denominator
	logic signed [51:0] we2_c, qe2_c;
	logic signed [43:0] denx_c;
	logic               v_s5, eo_s5;
	logic [47:0]        we2_s5, qe2_s5, sxy_s5;
	logic [46:0]        wz2_s5;
	logic signed [43:0] denx_s5;
	logic signed [25:0] qe_s5;
	logic signed [23:0] px_s5, py_s5;
	logic signed [24:0] pmz_s5;

	assign we2_c  = we_s4 * we_s4;
	assign qe2_c  = qe_s4 * qe_s4;
	assign denx_c = qe_s4 * TWO_MP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we2_s5  <= we2_c[47:0];
			qe2_s5  <= qe2_c[47:0];
			denx_s5 <= denx_c;
			qe_s5   <= qe_s4;
			sxy_s5  <= sxy_s4;
			wz2_s5  <= wz2_s4;
			px_s5   <= px_s4;
			py_s5   <= py_s4;
			pmz_s5  <= pmz_s4;
			eo_s5   <= eo_s4;
		end
	end

	// stage 6: invariant mass squared and Q2
	logic               v_s6, eo_s6;
	logic signed [50:0] m2_s6, q2_s6;
	logic signed [43:0] denx_s6;
	logic signed [25:0] qe_s6;
	logic signed [23:0] px_s6, py_s6;
	logic signed [24:0] pmz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m2_s6   <= $signed({3'b0, we2_s5}) - $signed({3'b0, sxy_s5})
				- $signed({4'b0, wz2_s5});
			q2_s6   <= $signed({3'b0, sxy_s5}) + $signed({4'b0, wz2_s5})
				- $signed({3'b0, qe2_s5});
			denx_s6 <= denx_s5;
			qe_s6   <= qe_s5;
			px_s6   <= px_s5;
			py_s6   <= py_s5;
			pmz_s6  <= pmz_s5;
			eo_s6   <= eo_s5;
		end
	end

	// W magnitude
	logic signed [50:0] m2_abs;
	sb2_t               sb2_in, sb2_out;
	logic               v_w;
	logic [24:0]        wroot;

	assign m2_abs = m2_s6[50] ? -m2_s6 : m2_s6;

	always_comb begin
		sb2_in      = '0;
		sb2_in.mneg = m2_s6[50];
		sb2_in.q2   = q2_s6;
		sb2_in.denx = denx_s6;
		sb2_in.qe   = qe_s6;
		sb2_in.px   = px_s6;
		sb2_in.py   = py_s6;
		sb2_in.pmz  = pmz_s6;
		sb2_in.eo   = eo_s6;
	end

	dekin_sqrt_pipe #(.N(25), .SW($bits(sb2_t))) u_sqrt_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (v_s6),
		.rad    (m2_abs[49:0]),
		.sb_in  (sb2_in),
		.vout   (v_w),
		.root   (wroot),
		.sb_out (sb2_out)
	);

	// stage 7: signed W, early-out decision, x division operands
	logic signed [31:0] w32_c;
	logic signed [50:0] q2_abs;
	logic signed [43:0] denx_abs;
	logic               v_s7;
	sb3_t               sb3_s7, sb3_out;
	logic [50:0]        xn_s7;
	logic [43:0]        xd_s7;

	assign w32_c    = sb2_out.mneg ? -$signed({7'b0, wroot}) : $signed({7'b0, wroot});
	assign q2_abs   = sb2_out.q2[50] ? -sb2_out.q2 : sb2_out.q2;
	assign denx_abs = sb2_out.denx[43] ? -sb2_out.denx : sb2_out.denx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb3_s7.w32     <= w32_c;
			sb3_s7.early   <= sb2_out.eo && (w32_c < W_CUT);
			sb3_s7.q2o     <= sat32($signed(sb2_out.q2[50:16]));
			sb3_s7.qe      <= sb2_out.qe;
			sb3_s7.px      <= sb2_out.px;
			sb3_s7.py      <= sb2_out.py;
			sb3_s7.pmz     <= sb2_out.pmz;
			sb3_s7.xneg    <= sb2_out.q2[50] ^ sb2_out.denx[43];
			sb3_s7.xnumneg <= sb2_out.q2[50];
			sb3_s7.xnz     <= |sb2_out.q2;
			sb3_s7.xdz     <= sb2_out.denx == '0;
			xn_s7          <= q2_abs;
			xd_s7          <= denx_abs;
		end
	end

	logic                 v_x;
	logic [0:0][QB-1:0]   xq;
	logic [0:0]           xovf;

	dekin_div_pipe #(.NW(51), .DW(44), .LANES(1), .SW($bits(sb3_t))) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (v_s7),
		.num    (xn_s7),
		.den    (xd_s7),
		.sb_in  (sb3_s7),
		.vout   (v_x),
		.quo    (xq),
		.ovf    (xovf),
		.sb_out (sb3_out)
	);

	// stage 8: Bjorken x
	logic               v_s8;
	sb3_t               sb3_s8;
	logic signed [31:0] xo_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_x;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb3_s8 <= sb3_out;
			xo_s8  <= ratio_fix(xq[0], xovf[0], sb3_out.xneg, sb3_out.xnumneg,
				sb3_out.xnz, sb3_out.xdz);
		end
	end

	// stage 9: x times twice the proton mass
	logic               v_s9;
	sb3_t               sb3_s9;
	logic signed [31:0] xo_s9;
	logic signed [49:0] xm_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb3_s9 <= sb3_s8;
			xo_s9  <= xo_s8;
			xm_s9  <= xo_s8 * TWO_MP;
		end
	end

	// stage 10: Breit energy
	logic               v_s10;
	sb3_t               sb3_s10;
	logic signed [31:0] xo_s10;
	logic signed [34:0] be_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (adv) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb3_s10 <= sb3_s9;
			xo_s10  <= xo_s9;
			be_s10  <= 35'($signed(xm_s9[49:16])) + 35'(sb3_s9.qe);
		end
	end

	// boost division operands
	logic signed [24:0]       bn_sgn [0:2];
	logic [2:0][24:0]         bn_abs;
	logic signed [34:0]       be_abs;
	sb4_t                     sb4_in, sb4_out;
	logic                     v_b;
	logic [2:0][QB-1:0]       bq;
	logic [2:0]               bovf;

	assign bn_sgn[0] = 25'(sb3_s10.px);
	assign bn_sgn[1] = 25'(sb3_s10.py);
	assign bn_sgn[2] = sb3_s10.pmz;
	assign be_abs    = be_s10[34] ? -be_s10 : be_s10;

	always_comb begin
		sb4_in       = '0;
		sb4_in.w32   = sb3_s10.w32;
		sb4_in.early = sb3_s10.early;
		sb4_in.q2o   = sb3_s10.q2o;
		sb4_in.qe    = sb3_s10.qe;
		sb4_in.xo    = xo_s10;
		sb4_in.xdz   = sb3_s10.xdz;
		sb4_in.bdz   = be_s10 == '0;
		sb4_in.bdneg = be_s10[34];
		for (int l = 0; l < 3; l++) begin
			bn_abs[l]      = bn_sgn[l][24] ? 25'(-bn_sgn[l]) : 25'(bn_sgn[l]);
			sb4_in.nneg[l] = bn_sgn[l][24];
			sb4_in.nnz[l]  = |bn_sgn[l];
		end
	end

	dekin_div_pipe #(.NW(25), .DW(35), .LANES(3), .SW($bits(sb4_t))) u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (v_s10),
		.num    (bn_abs),
		.den    (be_abs),
		.sb_in  (sb4_in),
		.vout   (v_b),
		.quo    (bq),
		.ovf    (bovf),
		.sb_out (sb4_out)
	);

	// output register
	logic signed [31:0] bst [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			bst[l] = ratio_fix(bq[l], bovf[l], sb4_out.nneg[l] ^ sb4_out.bdneg,
				sb4_out.nneg[l], sb4_out.nnz[l], sb4_out.bdz);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kin.valid <= 1'b0;
		else if (adv) kin.valid <= v_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kin.inv_mass_w <= sb4_out.w32;
			if (sb4_out.early) begin
				kin.q_squared       <= SENTINEL;
				kin.energy_transfer <= SENTINEL;
				kin.bjorken_x       <= SENTINEL;
				kin.boost_x         <= SENTINEL;
				kin.boost_y         <= SENTINEL;
				kin.boost_z         <= SENTINEL;
				kin.full_result     <= 1'b0;
				kin.divide_fault    <= 1'b0;
			end else begin
				kin.q_squared       <= sb4_out.q2o;
				kin.energy_transfer <= 32'(sb4_out.qe);
				kin.bjorken_x       <= sb4_out.xo;
				kin.boost_x         <= bst[0];
				kin.boost_y         <= bst[1];
				kin.boost_z         <= bst[2];
				kin.full_result     <= 1'b1;
				kin.divide_fault    <= sb4_out.xdz | sb4_out.bdz;
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
// Testbench for the electron kinematics unit: predicts every result and checks it beat by beat.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dekin_pkg::*;

	typedef struct {
		logic signed [31:0] w, q2, nu, xb, bx, by, bz;
		logic               full, fault;
	} kin_t;

	class kin_scoreboard;
		longint beam;
		bit     early;
		kin_t   pending_q[$];
		int     errors;

		function new();
			beam = BEAM_RST;
			early = EARLY_RST;
			errors = 0;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic signed [31:0] clip(longint v);
			if (v > longint'(S32_MAX)) return S32_MAX;
			if (v < longint'(S32_MIN)) return S32_MIN;
			return v[31:0];
		endfunction

		function logic signed [31:0] quotient(longint num, longint den, inout bit fault);
			bit neg;
			longint unsigned n, d, q, r, mag;
			neg = (num < 0) != (den < 0);
			n = num < 0 ? longint'(-num) : num;
			d = den < 0 ? longint'(-den) : den;
			if (d == 0) begin
				fault = 1;
				if (n == 0) return 0;
				return num < 0 ? S32_MIN : S32_MAX;
			end
			q = n / d;
			r = n % d;
			if (q >= 64'h8000_0000) mag = 64'd1 << 32;
			else mag = (q << 16) + (r << 16) / d;
			if (neg) begin
				if (mag >= 64'h8000_0000) return S32_MIN;
				return 32'(-longint'(mag));
			end
			if (mag > 64'h7FFF_FFFF) return S32_MAX;
			return mag[31:0];
		endfunction

		function void note(logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
			longint px, py, pz, ee, wz, we, m2, w, qe, q2, be;
			longint unsigned p2;
			bit fault;
			kin_t k;
			px = x; py = y; pz = z;
			fault = 0;
			p2 = px * px + py * py + pz * pz;
			ee = root(p2 + 64'd1121);
			wz = beam - pz;
			we = beam + longint'(MP_Q16) - ee;
			m2 = we * we - px * px - py * py - wz * wz;
			if (m2 >= 0) w = root(m2);
			else w = -longint'(root(-m2));
			k.w = clip(w);
			if (early && k.w < W_CUT) begin
				k.q2 = SENTINEL; k.nu = SENTINEL; k.xb = SENTINEL;
				k.bx = SENTINEL; k.by = SENTINEL; k.bz = SENTINEL;
				k.full = 0; k.fault = 0;
			end else begin
				qe = beam - ee;
				q2 = px * px + py * py + wz * wz - qe * qe;
				k.q2 = clip(q2 >>> 16);
				k.nu = clip(qe);
				k.xb = quotient(q2, longint'(TWO_MP) * qe, fault);
				be = qe + ((longint'(k.xb) * longint'(TWO_MP)) >>> 16);
				k.bx = quotient(px, be, fault);
				k.by = quotient(py, be, fault);
				k.bz = quotient(pz - beam, be, fault);
				k.full = 1;
				k.fault = fault;
			end
			pending_q.push_back(k);
		endfunction

		function void cmp(string f, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, f, $signed(e), $signed(a));
			end
		endfunction

		function void check(kin_t a);
			kin_t e;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual w=%0d", $time, a.w);
				return;
			end
			e = pending_q.pop_front();
			cmp("inv_mass_w", e.w, a.w);
			cmp("q_squared", e.q2, a.q2);
			cmp("energy_transfer", e.nu, a.nu);
			cmp("bjorken_x", e.xb, a.xb);
			cmp("boost_x", e.bx, a.bx);
			cmp("boost_y", e.by, a.by);
			cmp("boost_z", e.bz, a.bz);
			cmp("full_result", 32'(e.full), 32'(a.full));
			cmp("divide_fault", 32'(e.fault), 32'(a.fault));
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [BEAM_W-1:0] wr_data = '0;

	dekin_mom_if mom();
	dekin_kin_if kin();

	dis_electron_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .mom(mom), .kin(kin)
	);

	kin_scoreboard sb = new();
	bit  gaps_on = 1;
	bit  hold_req = 0;
	int  hold_left = 0;
	int  cycles = 0;
	kin_t got;

	always #6 clk = ~clk;

	initial begin
		mom.valid = 0;
		mom.mom_x = '0;
		mom.mom_y = '0;
		mom.mom_z = '0;
		kin.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (kin.valid && kin.ready) begin
			got.w = kin.inv_mass_w; got.q2 = kin.q_squared; got.nu = kin.energy_transfer;
			got.xb = kin.bjorken_x; got.bx = kin.boost_x; got.by = kin.boost_y;
			got.bz = kin.boost_z; got.full = kin.full_result; got.fault = kin.divide_fault;
			sb.check(got);
		end
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			kin.ready <= 0;
		end else if (!gaps_on) begin
			kin.ready <= 1;
		end else begin
			kin.ready <= ($urandom_range(99) >= 38);
		end
	end

	task automatic send(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		mom.valid <= 1;
		mom.mom_x <= x;
		mom.mom_y <= y;
		mom.mom_z <= z;
		do @(posedge clk); while (!mom.ready);
		sb.note(x, y, z);
		if (gaps_on && $urandom_range(99) < 38) begin
			mom.valid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		mom.valid <= 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic cfg(logic [CFG_IDX_W-1:0] idx, logic [BEAM_W-1:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == REG_BEAM) sb.beam = val;
		else if (idx == REG_EARLY) sb.early = val[0];
	endtask

	task automatic send_random(int n);
		logic [23:0] x, y, z;
		int e;
		repeat (n) begin
			if ($urandom_range(99) < 70) begin
				e = int'(sb.beam);
				z = 24'($urandom_range(e + 2000, 0));
				x = 24'($signed($urandom_range(524288)) - 262144);
				y = 24'($signed($urandom_range(524288)) - 262144);
			end else begin
				x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
			end
			send(x, y, z);
		end
	endtask

	task automatic send_directed();
		logic [23:0] e;
		e = 24'(sb.beam);
		send(24'h000000, 24'h000000, 24'h000000);
		send(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send(24'h800000, 24'h800000, 24'h800000);
		send(24'h7FFFFF, 24'h800000, 24'h000000);
		send(24'h000000, 24'h7FFFFF, 24'h800000);
		send(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send(24'h000000, 24'h000000, e);
		send(24'h010000, 24'h000000, e);
		send(24'h020000, 24'hFE0000, 24'h050000);
		send(24'h000000, 24'h000000, 24'h800000);
		send(24'h0A0000, 24'h000000, 24'h000000);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_directed();
		send_random(150);
		hold_req = 1;
		send_random(60);
		drain();
		cfg(REG_BEAM, 20'hFFFFF);
		cfg(REG_EARLY, 20'd0);
		cfg(8'd7, 20'h12345);
		send_directed();
		send_random(200);
		drain();
		gaps_on = 0;
		cfg(REG_BEAM, 20'd0);
		cfg(REG_EARLY, 20'd1);
		send_directed();
		send_random(200);
		drain();
		gaps_on = 1;
		cfg(REG_BEAM, 20'($urandom_range(20'hFFFFF)));
		cfg(REG_EARLY, 20'd0);
		send_directed();
		send_random(200);
		drain();
		cfg(REG_BEAM, BEAM_RST);
		send_random(200);
		drain();
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
